>>> src/sltie_pkg.sv
// shared types and constants for the simt lane integer execute block
package sltie_pkg;

	localparam int XLEN = 64;
	localparam int DATA_WIDTH_DEF = 64;

	typedef enum logic [4:0] {
		CMD_ADD       = 5'd0,
		CMD_SUB       = 5'd1,
		CMD_SLL       = 5'd2,
		CMD_SLT       = 5'd3,
		CMD_SLTU      = 5'd4,
		CMD_XOR       = 5'd5,
		CMD_SRL       = 5'd6,
		CMD_SRA       = 5'd7,
		CMD_OR        = 5'd8,
		CMD_AND       = 5'd9,
		CMD_MUL       = 5'd10,
		CMD_MULH      = 5'd11,
		CMD_MULHSU    = 5'd12,
		CMD_MULHU     = 5'd13,
		CMD_DIV       = 5'd14,
		CMD_DIVU      = 5'd15,
		CMD_REM       = 5'd16,
		CMD_REMU      = 5'd17,
		CMD_CZERO_EQZ = 5'd18,
		CMD_CZERO_NEZ = 5'd19
	} cmd_e;

	typedef enum logic [2:0] {
		MD_IDLE,
		MD_MUL,
		MD_DIV,
		MD_FIN,
		MD_DONE
	} md_state_e;

	typedef struct packed {
		logic [4:0]             command;
		logic signed [XLEN-1:0] operand_a;
		logic signed [XLEN-1:0] operand_b;
		logic                   active;
		logic                   last_lane;
	} in_t;

	typedef struct packed {
		logic signed [XLEN-1:0] result;
		logic                   write_enable;
		logic                   uses_muldiv;
		logic                   last_lane_out;
	} out_t;

	// queue entry between front and back
	typedef struct packed {
		logic [4:0]      command;
		logic [XLEN-1:0] a;
		logic [XLEN-1:0] b;
		logic            active;
		logic            last_lane;
		logic            muldiv;
	} qent_t;

	typedef struct packed {
		logic idle;
		logic done;
	} md_stat_t;

endpackage

>>> src/sltie_front.sv
// front end: accepts commands, classifies them and queues them for the back end
module sltie_front import sltie_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cmd_valid,
	output logic  cmd_stall,
	input  in_t   cmd,
	output logic  q_valid,
	output qent_t q_head,
	input  logic  q_pop
);

	qent_t      ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	qent_t      ent_new;

	assign cmd_stall = (cnt_q == 2'd2);
	assign push = cmd_valid && !cmd_stall;
	assign q_valid = (cnt_q != 2'd0);
	assign q_head = ent_q[rd_q];

	always_comb begin
		ent_new.command = cmd.command;
		ent_new.a = cmd.operand_a;
		ent_new.b = cmd.operand_b;
		ent_new.active = cmd.active;
		ent_new.last_lane = cmd.last_lane;
		ent_new.muldiv = (cmd.command >= CMD_MUL) && (cmd.command <= CMD_REMU);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (q_pop) rd_q <= !rd_q;
			if (push && !q_pop) cnt_q <= cnt_q + 2'd1;
			else if (!push && q_pop) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= ent_new;
	end

endmodule

>>> src/sltie_muldiv.sv
// iterative multiply and divide unit
module sltie_muldiv import sltie_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [4:0]            command,
	input  logic [DATA_WIDTH-1:0] a,
	input  logic [DATA_WIDTH-1:0] b,
	input  logic                  take,
	output md_stat_t              stat,
	output logic [DATA_WIDTH-1:0] result
);

	localparam int W = DATA_WIDTH;
	localparam int H = (W + 1) / 2;
	localparam int CW = $clog2(W);

	md_state_e     state_q, state_nx;
	cmd_e          cmd_q;
	logic [W-1:0]  a_q, b_q, bmag_q, quo_q, rem_q, res_q;
	logic [4*H-1:0] acc_q;
	logic [1:0]    step_q;
	logic [CW-1:0] cnt_q;
	logic          nega_q, negq_q;
	logic          is_div, is_sdiv;

	logic [2*H-1:0] ap, bp;
	logic [H-1:0]   ah, bh;
	logic [2*H-1:0] prod;
	logic [4*H-1:0] acc_add;
	logic [W:0]     rem_sh, diff;
	logic [W-1:0]   hi, fin;

	assign is_div = (command >= CMD_DIV) && (command <= CMD_REMU);
	assign is_sdiv = (command == CMD_DIV) || (command == CMD_REM);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			MD_IDLE: if (start) state_nx = is_div ? MD_DIV : MD_MUL;
			MD_MUL:  if (step_q == 2'd3) state_nx = MD_FIN;
			MD_DIV:  if (cnt_q == CW'(W - 1)) state_nx = MD_FIN;
			MD_FIN:  state_nx = MD_DONE;
			MD_DONE: if (take) state_nx = MD_IDLE;
			default: state_nx = MD_IDLE;
		endcase
	end

	// status outputs
	always_comb begin
		stat.idle = (state_q == MD_IDLE);
		stat.done = (state_q == MD_DONE);
	end

	assign result = res_q;

	// one half-word partial product per step
	always_comb begin
		ap = (2*H)'(a_q);
		bp = (2*H)'(b_q);
		ah = step_q[1] ? ap[2*H-1:H] : ap[H-1:0];
		bh = step_q[0] ? bp[2*H-1:H] : bp[H-1:0];
		prod = ah * bh;
		unique case ({1'b0, step_q[1]} + {1'b0, step_q[0]})
			2'd0:    acc_add = (4*H)'(prod);
			2'd1:    acc_add = (4*H)'(prod) << H;
			default: acc_add = (4*H)'(prod) << (2*H);
		endcase
	end

	// restoring divide, one quotient bit per cycle
	always_comb begin
		rem_sh = {rem_q, quo_q[W-1]};
		diff = rem_sh - {1'b0, bmag_q};
	end

	always_comb begin
		hi = acc_q[2*W-1:W];
		if ((cmd_q == CMD_MULH || cmd_q == CMD_MULHSU) && a_q[W-1]) hi = hi - b_q;
		if (cmd_q == CMD_MULH && b_q[W-1]) hi = hi - a_q;
		unique case (cmd_q)
			CMD_MUL:  fin = acc_q[W-1:0];
			CMD_DIV:  fin = (b_q == '0) ? '1 : (negq_q ? -quo_q : quo_q);
			CMD_DIVU: fin = (b_q == '0) ? '1 : quo_q;
			CMD_REM:  fin = (b_q == '0) ? a_q : (nega_q ? -rem_q : rem_q);
			CMD_REMU: fin = (b_q == '0) ? a_q : rem_q;
			default:  fin = hi;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == MD_IDLE && start) begin
			cmd_q <= cmd_e'(command);
			a_q <= a;
			b_q <= b;
			acc_q <= '0;
			step_q <= 2'd0;
			cnt_q <= '0;
			rem_q <= '0;
			quo_q <= (is_sdiv && a[W-1]) ? -a : a;
			bmag_q <= (is_sdiv && b[W-1]) ? -b : b;
			nega_q <= is_sdiv && a[W-1];
			negq_q <= is_sdiv && (a[W-1] ^ b[W-1]);
		end
		if (state_q == MD_MUL) begin
			acc_q <= acc_q + acc_add;
			step_q <= step_q + 2'd1;
		end
		if (state_q == MD_DIV) begin
			rem_q <= diff[W] ? rem_sh[W-1:0] : diff[W-1:0];
			quo_q <= {quo_q[W-2:0], !diff[W]};
			cnt_q <= cnt_q + CW'(1);
		end
		if (state_q == MD_FIN) res_q <= fin;
	end

endmodule

>>> src/sltie_back.sv
// back end: combinational alu, muldiv unit dispatch and output register
module sltie_back import sltie_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  q_valid,
	input  qent_t q_head,
	output logic  q_pop,
	output logic  res_valid,
	input  logic  res_stall,
	output out_t  res
);

	localparam int W = DATA_WIDTH;
	localparam int SW = $clog2(W);

	logic [W-1:0]  a_w, b_w, alu_res, md_res;
	logic [SW-1:0] sh;
	md_stat_t      md_stat;
	logic          use_unit, out_free, md_take, md_start;
	logic          res_valid_q;
	out_t          res_q;
	logic          last_q;

	assign a_w = q_head.a[W-1:0];
	assign b_w = q_head.b[W-1:0];
	assign sh = q_head.b[SW-1:0];

	always_comb begin
		unique case (cmd_e'(q_head.command))
			CMD_ADD:       alu_res = a_w + b_w;
			CMD_SUB:       alu_res = a_w - b_w;
			CMD_SLL:       alu_res = a_w << sh;
			CMD_SLT:       alu_res = W'($signed(a_w) < $signed(b_w));
			CMD_SLTU:      alu_res = W'(a_w < b_w);
			CMD_XOR:       alu_res = a_w ^ b_w;
			CMD_SRL:       alu_res = a_w >> sh;
			CMD_SRA:       alu_res = W'($signed(a_w) >>> sh);
			CMD_OR:        alu_res = a_w | b_w;
			CMD_AND:       alu_res = a_w & b_w;
			CMD_CZERO_EQZ: alu_res = (b_w == '0) ? '0 : a_w;
			CMD_CZERO_NEZ: alu_res = (b_w != '0) ? '0 : a_w;
			default:       alu_res = '0;
		endcase
	end

	assign use_unit = q_head.muldiv && q_head.active;
	assign out_free = !res_valid_q || !res_stall;
	assign q_pop = q_valid && md_stat.idle && (use_unit || out_free);
	assign md_start = q_pop && use_unit;
	assign md_take = md_stat.done && out_free;

	sltie_muldiv #(.DATA_WIDTH(DATA_WIDTH)) u_muldiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (md_start),
		.command (q_head.command),
		.a       (a_w),
		.b       (b_w),
		.take    (md_take),
		.stat    (md_stat),
		.result  (md_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			if ((q_pop && !use_unit) || md_take) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (md_start) last_q <= q_head.last_lane;
		if (q_pop && !use_unit) begin
			res_q.result <= q_head.active ? XLEN'($signed(alu_res)) : '0;
			res_q.write_enable <= q_head.active;
			res_q.uses_muldiv <= q_head.muldiv;
			res_q.last_lane_out <= q_head.last_lane;
		end else if (md_take) begin
			res_q.result <= XLEN'($signed(md_res));
			res_q.write_enable <= 1'b1;
			res_q.uses_muldiv <= 1'b1;
			res_q.last_lane_out <= last_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

	a_no_pop_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		md_stat.done |-> !q_pop)
		else $error("queue popped while muldiv result pending");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		md_start |=> !md_stat.idle)
		else $error("muldiv did not leave idle after start");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_stall) |-> !md_take && !(q_pop && !use_unit))
		else $error("output register loaded while held");

endmodule

>>> src/simt_lane_integer_execute_top.sv
// top level of the simt lane integer execute block
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+---------------
//  command | cmd_valid | cmd_stall | cmd (in_t)
//  result  | res_valid | res_stall | res (out_t)
//
// alu ops and inactive lanes: one transfer per cycle unless res_stall or a busy muldiv unit holds the flow
// mul/mulh/mulhsu/mulhu hold the shared muldiv unit through four partial products, a final step and done
// div/rem hold it while the quotient is formed, one quotient bit per cycle
// results leave in command order; later commands wait in a two-entry queue
// reset clears the queue and the output valid flag; res_stall holds the result in place
module simt_lane_integer_execute_top import sltie_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  in_t  cmd,
	output logic res_valid,
	input  logic res_stall,
	output out_t res
);

	logic  q_valid;
	qent_t q_head;
	logic  q_pop;

	sltie_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop)
	);

	sltie_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

>>> dv/simt_lane_integer_execute_top_tb.sv
// testbench for the simt lane integer execute block: directed table plus random lanes
`timescale 1ns / 100ps

module simt_lane_integer_execute_top_tb;
	import sltie_pkg::*;

	localparam int DW = DATA_WIDTH_DEF;
	localparam int N_RANDOM = 1150;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 200;
	localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MAX64 = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] ONES = '1;

	typedef struct {
		in_t  stim;
		logic known;
		out_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	in_t  cmd = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	out_t res;

	out_t expected_q[$];
	int   errors = 0;
	int   idle_cycles = 0;
	bit   quiet = 1'b0;
	row_t rows[$];

	simt_lane_integer_execute_top #(.DATA_WIDTH(DW)) uut (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
		.cmd(cmd), .res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [63:0] lane_alu(logic [4:0] op, logic [63:0] a, logic [63:0] b);
		logic [127:0] prod;
		logic [63:0] ma, mb, q, r;
		logic [5:0] sh;
		sh = b[5:0];
		case (op)
			CMD_ADD: return a + b;
			CMD_SUB: return a - b;
			CMD_SLL: return a << sh;
			CMD_SLT: return {63'd0, $signed(a) < $signed(b)};
			CMD_SLTU: return {63'd0, a < b};
			CMD_XOR: return a ^ b;
			CMD_SRL: return a >> sh;
			CMD_SRA: return $signed(a) >>> sh;
			CMD_OR: return a | b;
			CMD_AND: return a & b;
			CMD_MUL: return a * b;
			CMD_MULH: begin
				prod = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
				return prod[127:64];
			end
			CMD_MULHSU: begin
				prod = {{64{a[63]}}, a} * {64'd0, b};
				return prod[127:64];
			end
			CMD_MULHU: begin
				prod = {64'd0, a} * {64'd0, b};
				return prod[127:64];
			end
			CMD_DIV, CMD_REM: begin
				if (b == 0)
					return (op == CMD_DIV) ? ONES : a;
				ma = a[63] ? -a : a;
				mb = b[63] ? -b : b;
				q = ma / mb;
				r = ma % mb;
				if (op == CMD_DIV)
					return (a[63] != b[63]) ? -q : q;
				return a[63] ? -r : r;
			end
			CMD_DIVU: return (b == 0) ? ONES : a / b;
			CMD_REMU: return (b == 0) ? a : a % b;
			CMD_CZERO_EQZ: return (b == 0) ? 64'd0 : a;
			CMD_CZERO_NEZ: return (b != 0) ? 64'd0 : a;
			default: return 64'd0;
		endcase
	endfunction

	function automatic out_t lane_result(in_t s);
		out_t o;
		o.result = s.active ? lane_alu(s.command, s.operand_a, s.operand_b) : 64'd0;
		o.write_enable = s.active;
		o.uses_muldiv = (s.command >= CMD_MUL && s.command <= CMD_REMU);
		o.last_lane_out = s.last_lane;
		return o;
	endfunction

	function automatic logic [63:0] rand64();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: v = MIN64;
			1: v = MAX64;
			2: v = ONES;
			3: v = 64'd0;
			4: v = 64'($urandom_range(0, 70));
			5: v = -64'($urandom_range(0, 70));
			default: ;
		endcase
		return v;
	endfunction

	function automatic row_t mk(logic [4:0] op, logic [63:0] a, logic [63:0] b, logic act,
			logic last, logic known, logic [63:0] r);
		row_t x;
		x.stim.command = op;
		x.stim.operand_a = a;
		x.stim.operand_b = b;
		x.stim.active = act;
		x.stim.last_lane = last;
		x.known = known;
		x.want.result = r;
		x.want.write_enable = act;
		x.want.uses_muldiv = (op >= CMD_MUL && op <= CMD_REMU);
		x.want.last_lane_out = last;
		return x;
	endfunction

	// result side: random stall, compare each transfer with the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, res);
					errors++;
				end else begin
					if (res !== expected_q[0]) begin
						$display("%0t: mismatch expected %h actual %h", $time,
							expected_q[0], res);
						errors++;
					end
					void'(expected_q.pop_front());
				end
			end
			if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			res_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 12);
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT) begin
			$display("** simt_lane_integer_execute_top: FAILED **");
			$finish;
		end
	end

	task automatic send_lane(in_t s, logic known, out_t want);
		while (!quiet && $urandom_range(0, 99) < 12) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= s;
		do @(posedge clk); while (cmd_stall);
		expected_q.push_back(known ? want : lane_result(s));
	endtask

	initial begin
		in_t s;
		out_t none;
		none = '0;
		// extremes and special cases
		rows.push_back(mk(CMD_ADD, MAX64, 64'd1, 1'b1, 1'b0, 1'b1, MIN64));
		rows.push_back(mk(CMD_SUB, MIN64, 64'd1, 1'b1, 1'b1, 1'b1, MAX64));
		rows.push_back(mk(CMD_SLL, 64'd1, 64'd127, 1'b1, 1'b0, 1'b1, MIN64));
		rows.push_back(mk(CMD_SLT, MIN64, MAX64, 1'b1, 1'b0, 1'b1, 64'd1));
		rows.push_back(mk(CMD_SLTU, MIN64, MAX64, 1'b1, 1'b0, 1'b1, 64'd0));
		rows.push_back(mk(CMD_XOR, ONES, MAX64, 1'b1, 1'b0, 1'b1, MIN64));
		rows.push_back(mk(CMD_SRL, MIN64, 64'd63, 1'b1, 1'b0, 1'b1, 64'd1));
		rows.push_back(mk(CMD_SRA, MIN64, 64'd63, 1'b1, 1'b0, 1'b1, ONES));
		rows.push_back(mk(CMD_OR, MIN64, MAX64, 1'b1, 1'b0, 1'b1, ONES));
		rows.push_back(mk(CMD_AND, MIN64, MAX64, 1'b1, 1'b0, 1'b1, 64'd0));
		rows.push_back(mk(CMD_MUL, MAX64, MAX64, 1'b1, 1'b0, 1'b0, 64'd0));
		rows.push_back(mk(CMD_MULH, MIN64, MIN64, 1'b1, 1'b0, 1'b0, 64'd0));
		rows.push_back(mk(CMD_MULHSU, ONES, ONES, 1'b1, 1'b0, 1'b0, 64'd0));
		rows.push_back(mk(CMD_MULHU, ONES, ONES, 1'b1, 1'b0, 1'b0, 64'd0));
		rows.push_back(mk(CMD_DIV, 64'd77, 64'd0, 1'b1, 1'b0, 1'b1, ONES));
		rows.push_back(mk(CMD_DIV, MIN64, ONES, 1'b1, 1'b0, 1'b1, MIN64));
		rows.push_back(mk(CMD_DIVU, 64'd5, 64'd0, 1'b1, 1'b0, 1'b1, ONES));
		rows.push_back(mk(CMD_REM, -64'd7, 64'd0, 1'b1, 1'b0, 1'b1, -64'd7));
		rows.push_back(mk(CMD_REM, MIN64, ONES, 1'b1, 1'b0, 1'b1, 64'd0));
		rows.push_back(mk(CMD_REMU, ONES, 64'd0, 1'b1, 1'b0, 1'b1, ONES));
		rows.push_back(mk(CMD_CZERO_EQZ, 64'd9, 64'd0, 1'b1, 1'b0, 1'b1, 64'd0));
		rows.push_back(mk(CMD_CZERO_NEZ, 64'd9, 64'd0, 1'b1, 1'b0, 1'b1, 64'd9));
		rows.push_back(mk(CMD_DIV, MAX64, 64'd3, 1'b0, 1'b1, 1'b1, 64'd0));
		rows.push_back(mk(5'd31, ONES, ONES, 1'b1, 1'b1, 1'b1, 64'd0));
		rows.push_back(mk(5'd20, ONES, ONES, 1'b0, 1'b0, 1'b1, 64'd0));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i])
			send_lane(rows[i].stim, rows[i].known, rows[i].want);
		cmd_valid <= 1'b0;

		// sender holds off until the pipeline has drained
		wait (expected_q.size() == 0);
		@(posedge clk);
		for (int n = 0; n < N_RANDOM; n++) begin
			quiet = (n >= 400 && n < 550);
			s.command = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(20, 31))
				: 5'($urandom_range(0, 19));
			s.operand_a = rand64();
			s.operand_b = rand64();
			s.active = ($urandom_range(0, 9) != 0);
			s.last_lane = 1'($urandom_range(0, 1));
			send_lane(s, 1'b0, none);
		end
		cmd_valid <= 1'b0;
		quiet = 1'b0;
		wait (expected_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0)
			$display("** simt_lane_integer_execute_top: PASSED **");
		else
			$display("** simt_lane_integer_execute_top: FAILED **");
		$finish;
	end

endmodule

>>> filelist.f
src/sltie_pkg.sv
src/sltie_front.sv
src/sltie_muldiv.sv
src/sltie_back.sv
src/simt_lane_integer_execute_top.sv
dv/simt_lane_integer_execute_top_tb.sv
